>>> design/dmsf_pkg.sv
// Shared types, constants and helpers for the depth mixture sigma filter.
`timescale 1ns / 1ps

package dmsf_pkg;

   // Fixed field widths
   localparam int DEPTH_W = 16;
   localparam int SIGMA_W = 24;
   localparam int FRAME_W = 11;

   // Largest row count a frame may have
   localparam int MAX_ROWS = 1024;

   // Saturated sigma
   localparam logic [SIGMA_W-1:0] SIGMA_SAT = 24'hFFFFFF;

   // Register indexes (byte address 4*i)
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MIN_DEPTH    = 2'd2;
   localparam logic [1:0] REG_SIGMA_FLOOR  = 2'd3;

   // Register reset values
   localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 11'd451;
   localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 11'd361;
   localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST    = 16'd500;
   localparam logic [SIGMA_W-1:0] SIGMA_FLOOR_RST  = 24'd167;

   // Sequencer states
   typedef enum logic [11:0] {
      S_CLEAR = 12'b0000_0000_0001,
      S_IDLE  = 12'b0000_0000_0010,
      S_MU    = 12'b0000_0000_0100,
      S_SHIFT = 12'b0000_0000_1000,
      S_POS   = 12'b0000_0001_0000,
      S_ACC   = 12'b0000_0010_0000,
      S_DIVZ  = 12'b0000_0100_0000,
      S_DIVM  = 12'b0000_1000_0000,
      S_SQ    = 12'b0001_0000_0000,
      S_VAR   = 12'b0010_0000_0000,
      S_SQRT  = 12'b0100_0000_0000,
      S_OUT   = 12'b1000_0000_0000
   } state_type;

   // 1-2-1 / 2-4-2 / 1-2-1 weights as left shifts, window entry 0..8 in raster order
   function automatic logic [1:0] weight_shift(input logic [3:0] k);
      logic [1:0] sh;
      unique case (k)
         4'd4:                      sh = 2'd2;
         4'd1, 4'd3, 4'd5, 4'd7:    sh = 2'd1;
         default:                   sh = 2'd0;
      endcase
      return sh;
   endfunction

endpackage

>>> design/dmsf_req_if.sv
// Input channel: depth pixel beats with valid/ready handshake.
`timescale 1ns / 1ps

interface dmsf_req_if;
   logic                          valid;
   logic                          ready;
   logic [dmsf_pkg::DEPTH_W-1:0]  depth_mm;
   logic [dmsf_pkg::SIGMA_W-1:0]  sigma_in;
   logic                          drain;

   modport source (output valid, output depth_mm, output sigma_in, output drain,
                   input ready);
   modport sink   (input valid, input depth_mm, input sigma_in, input drain,
                   output ready);
endinterface

>>> design/dmsf_rsp_if.sv
// Result channel: fused sigma beats with valid/ready handshake.
`timescale 1ns / 1ps

interface dmsf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dmsf_pkg::SIGMA_W-1:0]  sigma_out;
   logic                          frame_last;

   modport source (output valid, output sigma_out, output frame_last, input ready);
   modport sink   (input valid, input sigma_out, input frame_last, output ready);
endinterface

>>> design/depth_mixture_sigma_filter.sv
// Top level of the depth mixture sigma filter: line stores, window and shared sequencer.
`timescale 1ns / 1ps

// 3x3 Gaussian-mixture fusion of inverse-depth sigma over a raster pixel stream. Each
// accepted beat is worked one at a time by a sequencer around one restoring shift-subtract
// unit (divide and square root) and one 24x24 multiplier; req is not ready meanwhile.
// Per pixel: accept, mu = (1000<<F)/depth (MW = F+10, skipped for drain beats), then a
// window shift; when a result leaves, the raster index is split by the width
// (EW = clog2(MAX_WIDTH+1)+11), then for interior pixels the valid window entries are
// accumulated, two divides follow (SW = MW+4, NQW = 2*MW+5), mu_z is squared, the
// variance is formed and, unless clamped or saturated, its square root taken; last the
// output register is loaded. A result beat waits in an output register while the next
// pixel is worked; the output state stalls while that register still holds an unaccepted
// beat. After reset a clearing pass over all MAX_WIDTH columns resets the per-column
// real-pixel flags before the first beat is taken; register writes are taken throughout.
module depth_mixture_sigma_filter #(
   parameter int MAX_WIDTH       = 1024,
   parameter int SIGMA_FRAC_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   dmsf_req_if.sink          req_ch,
   dmsf_rsp_if.source        rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int AW   = $clog2(MAX_WIDTH);
   localparam int CW   = $clog2(MAX_WIDTH + 1);
   localparam int EW   = CW + dmsf_pkg::FRAME_W;
   localparam int MW   = SIGMA_FRAC_BITS + 10;
   localparam int H    = (MW + 1) / 2;
   localparam int SW   = MW + 4;
   localparam int NQW  = 2 * MW + 5;
   localparam int CNTW = $clog2(NQW + 1);
   localparam logic [MW-1:0] MU_NUM = {10'd1000, {SIGMA_FRAC_BITS{1'b0}}};

   typedef struct packed {
      logic [dmsf_pkg::DEPTH_W-1:0] depth;
      logic [dmsf_pkg::SIGMA_W-1:0] sigma;
      logic [MW-1:0]                mu;
   } entry_type;

   // Registers
   dmsf_pkg::state_type state_ff, state_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [10:0]     fw_ff, fw_in, fh_ff, fh_in;
   logic [15:0]     mind_ff, mind_in;
   logic [23:0]     sfloor_ff, sfloor_in;
   logic [CW-1:0]   col_ff, col_in, col_cur_ff, col_cur_in;
   logic [EW-1:0]   emit_ff, emit_in, pend_ff, pend_in;
   logic [15:0]     in_depth_ff, in_depth_in;
   logic [23:0]     in_sigma_ff, in_sigma_in;
   logic            real_ff, real_in;
   entry_type       win_ff [9];
   entry_type       win_in [9];
   logic [2:0]      mreal_ff, mreal_in;
   logic [NQW-1:0]  nq_ff, nq_in, acc_ff, acc_in;
   logic [15:0]     rem_ff, rem_in, dvs_ff, dvs_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [3:0]      ent_ff, ent_in;
   logic [2:0]      ph_ff, ph_in;
   logic [47:0]     prod_ff, prod_in;
   logic [SW-1:0]   smu_ff, smu_in;
   logic [4:0]      sw_ff, sw_in;
   logic [MW-1:0]   muz_ff, muz_in;
   logic [24:0]     sr_ff, sr_in;
   logic [23:0]     root_ff, root_in;
   logic [23:0]     res_ff, res_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [23:0]     rsp_sigma_ff, rsp_sigma_in;
   logic            rsp_last_ff, rsp_last_in;

   // Line stores and read registers
   entry_type       top_mem  [MAX_WIDTH];
   entry_type       mid_mem  [MAX_WIDTH];
   logic            real_mem [MAX_WIDTH];
   entry_type       top_rd_ff, mid_rd_ff;
   logic            mreal_rd_ff;

   logic            rd_en, mem_we, real_we, real_wd;
   logic [AW-1:0]   rd_addr, wr_addr, real_addr;
   entry_type       new_ent;

   // Frame geometry after clamping
   logic [CW-1:0]   wd;
   logic [10:0]     ht;
   logic [EW-1:0]   fs;
   logic [13:0]     fw_x;

   always_comb begin
      fw_x = 14'(fw_ff);
      if (fw_x < 14'd3) begin
         wd = CW'(3);
      end else if (fw_x > 14'(MAX_WIDTH)) begin
         wd = CW'(MAX_WIDTH);
      end else begin
         wd = CW'(fw_ff);
      end
      if (fh_ff < 11'd3) begin
         ht = 11'd3;
      end else if (fh_ff > 11'(dmsf_pkg::MAX_ROWS)) begin
         ht = 11'(dmsf_pkg::MAX_ROWS);
      end else begin
         ht = fh_ff;
      end
      fs = EW'(wd) * EW'(ht);
   end

   // Configuration port
   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      fw_in     = fw_ff;
      fh_in     = fh_ff;
      mind_in   = mind_ff;
      sfloor_in = sfloor_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            dmsf_pkg::REG_FRAME_WIDTH:  fw_in     = csr_pwdata[10:0];
            dmsf_pkg::REG_FRAME_HEIGHT: fh_in     = csr_pwdata[10:0];
            dmsf_pkg::REG_MIN_DEPTH:    mind_in   = csr_pwdata[15:0];
            dmsf_pkg::REG_SIGMA_FLOOR:  sfloor_in = csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         dmsf_pkg::REG_FRAME_WIDTH:  csr_prdata = 32'(fw_ff);
         dmsf_pkg::REG_FRAME_HEIGHT: csr_prdata = 32'(fh_ff);
         dmsf_pkg::REG_MIN_DEPTH:    csr_prdata = 32'(mind_ff);
         dmsf_pkg::REG_SIGMA_FLOOR:  csr_prdata = 32'(sfloor_ff);
         default:                    csr_prdata = 32'd0;
      endcase
   end

   // Handshake outputs
   assign req_ch.ready      = (state_ff == dmsf_pkg::S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sigma_out  = rsp_sigma_ff;
   assign rsp_ch.frame_last = rsp_last_ff;

   // Shared shift-subtract unit: one divide step and one square-root step
   logic [16:0] div_t, div_r;
   logic        div_ge;
   logic [NQW-1:0] div_nq;
   logic [26:0] sq_t, sq_trial, sq_r;
   logic        sq_ge;

   always_comb begin
      div_t   = {rem_ff, nq_ff[NQW-1]};
      div_ge  = div_t >= {1'b0, dvs_ff};
      div_r   = div_ge ? (div_t - {1'b0, dvs_ff}) : div_t;
      div_nq  = {nq_ff[NQW-2:0], div_ge};
      sq_t    = {sr_ff, nq_ff[47:46]};
      sq_trial = {1'b0, root_ff, 2'b01};
      sq_ge   = sq_t >= sq_trial;
      sq_r    = sq_ge ? (sq_t - sq_trial) : sq_t;
   end

   // Current window entry, its weight and validity
   entry_type   cur;
   logic [1:0]  wsh;
   logic        cur_ok;
   logic [MW-1:0] mu_src;
   logic [23:0] mu_lo, mu_hi;

   always_comb begin
      cur    = win_ff[ent_ff];
      wsh    = dmsf_pkg::weight_shift(ent_ff);
      cur_ok = (cur.depth > mind_ff) && (cur.sigma > sfloor_ff);
      mu_src = (state_ff == dmsf_pkg::S_SQ) ? muz_ff : cur.mu;
      mu_lo  = 24'(mu_src[H-1:0]);
      mu_hi  = 24'(mu_src[MW-1:H]);
   end

   // Sequencer
   logic [CW-1:0]  col_a, col_n;
   logic [EW-1:0]  emit_a, emit_n, pend_n, er;
   logic [CW-1:0]  ec;
   logic           interior, acc_last;
   logic [23:0]    mul_a, mul_b;
   logic [5:0]     add_sh;
   logic           add_en;
   logic [SW-1:0]  smu_nx;
   logic [4:0]     sw_nx;
   logic [NQW:0]   var_full;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      col_in       = col_ff;
      col_cur_in   = col_cur_ff;
      emit_in      = emit_ff;
      pend_in      = pend_ff;
      in_depth_in  = in_depth_ff;
      in_sigma_in  = in_sigma_ff;
      real_in      = real_ff;
      win_in       = win_ff;
      mreal_in     = mreal_ff;
      nq_in        = nq_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      cnt_in       = cnt_ff;
      ent_in       = ent_ff;
      ph_in        = ph_ff;
      smu_in       = smu_ff;
      sw_in        = sw_ff;
      muz_in       = muz_ff;
      sr_in        = sr_ff;
      root_in      = root_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_sigma_in = rsp_sigma_ff;
      rsp_last_in  = rsp_last_ff;
      rd_en        = 1'b0;
      mem_we       = 1'b0;
      real_we      = 1'b0;
      real_wd      = 1'b0;
      rd_addr      = col_ff[AW-1:0];
      real_addr    = col_cur_ff[AW-1:0];
      mul_a        = 24'd0;
      mul_b        = 24'd0;
      add_sh       = 6'd0;
      add_en       = 1'b0;
      col_a        = (col_ff >= wd) ? '0 : col_ff;
      emit_a       = (emit_ff >= fs) ? '0 : emit_ff;
      col_n        = col_cur_ff + CW'(1);
      emit_n       = emit_ff + EW'(1);
      pend_n       = pend_ff;
      er           = nq_ff[EW-1:0];
      ec           = rem_ff[CW-1:0];
      interior     = (er != '0) && (({1'b0, er} + (EW+1)'(1)) < (EW+1)'(ht))
                     && (ec != '0) && (({1'b0, ec} + (CW+1)'(1)) < {1'b0, wd});
      smu_nx       = smu_ff;
      sw_nx        = sw_ff;
      acc_last     = 1'b0;
      var_full     = {1'b0, nq_ff} - {1'b0, acc_ff};
      new_ent      = '0;
      if (real_ff) begin
         new_ent.depth = in_depth_ff;
         new_ent.sigma = in_sigma_ff;
         new_ent.mu    = nq_ff[MW-1:0];
      end

      unique case (state_ff)
         // reset the per-column real flags
         dmsf_pkg::S_CLEAR: begin
            real_we   = 1'b1;
            real_addr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_WIDTH - 1)) begin
               state_in = dmsf_pkg::S_IDLE;
            end
         end

         // take a beat, wrap counters, start the line store read
         dmsf_pkg::S_IDLE: begin
            if (req_ch.valid && !(req_ch.drain && pend_ff == '0)) begin
               col_in      = col_a;
               col_cur_in  = col_a;
               emit_in     = emit_a;
               rd_en       = 1'b1;
               rd_addr     = col_a[AW-1:0];
               in_depth_in = req_ch.depth_mm;
               in_sigma_in = req_ch.sigma_in;
               real_in     = !req_ch.drain;
               if (!req_ch.drain) begin
                  nq_in    = {MU_NUM, {(NQW-MW){1'b0}}};
                  dvs_in   = req_ch.depth_mm;
                  rem_in   = '0;
                  cnt_in   = CNTW'(MW);
                  state_in = dmsf_pkg::S_MU;
               end else begin
                  state_in = dmsf_pkg::S_SHIFT;
               end
            end
         end

         // mu = (1000 << F) / depth
         dmsf_pkg::S_MU: begin
            if (cnt_ff != '0) begin
               nq_in  = div_nq;
               rem_in = div_r[15:0];
               cnt_in = cnt_ff - CNTW'(1);
            end else begin
               state_in = dmsf_pkg::S_SHIFT;
            end
         end

         // shift the window, update line stores and raster position
         dmsf_pkg::S_SHIFT: begin
            mem_we  = 1'b1;
            real_we = 1'b1;
            real_wd = real_ff;
            for (int i = 0; i < 3; i++) begin
               win_in[3*i]   = win_ff[3*i+1];
               win_in[3*i+1] = win_ff[3*i+2];
            end
            win_in[2] = top_rd_ff;
            win_in[5] = mid_rd_ff;
            win_in[8] = new_ent;
            mreal_in  = {mreal_rd_ff, mreal_ff[2], mreal_ff[1]};
            col_in    = (col_n >= wd) ? '0 : col_n;
            pend_n    = pend_ff + EW'(real_ff);
            pend_in   = pend_n;
            if (!mreal_ff[2]) begin
               if (!real_ff && pend_n == '0) begin
                  col_in  = '0;
                  emit_in = '0;
               end
               state_in = dmsf_pkg::S_IDLE;
            end else begin
               nq_in    = {emit_ff, {(NQW-EW){1'b0}}};
               dvs_in   = 16'(wd);
               rem_in   = '0;
               cnt_in   = CNTW'(EW);
               state_in = dmsf_pkg::S_POS;
            end
         end

         // row and column of the result from its raster index
         dmsf_pkg::S_POS: begin
            if (cnt_ff != '0) begin
               nq_in  = div_nq;
               rem_in = div_r[15:0];
               cnt_in = cnt_ff - CNTW'(1);
            end else if (interior) begin
               acc_in   = '0;
               smu_in   = '0;
               sw_in    = '0;
               ent_in   = '0;
               ph_in    = '0;
               state_in = dmsf_pkg::S_ACC;
            end else begin
               res_in   = win_ff[4].sigma;
               state_in = dmsf_pkg::S_OUT;
            end
         end

         // accumulate w*(s^2 + mu^2), w*mu and w over valid entries
         dmsf_pkg::S_ACC: begin
            unique case (ph_ff)
               3'd0: begin
                  if (cur_ok) begin
                     mul_a = cur.sigma;
                     mul_b = cur.sigma;
                     ph_in = 3'd1;
                  end else begin
                     acc_last = 1'b1;
                  end
               end
               3'd1: begin
                  add_en = 1'b1;
                  add_sh = 6'(wsh);
                  mul_a  = mu_lo;
                  mul_b  = mu_lo;
                  ph_in  = 3'd2;
               end
               3'd2: begin
                  add_en = 1'b1;
                  add_sh = 6'(wsh);
                  mul_a  = mu_lo;
                  mul_b  = mu_hi;
                  ph_in  = 3'd3;
               end
               3'd3: begin
                  add_en = 1'b1;
                  add_sh = 6'(wsh) + 6'(H + 1);
                  mul_a  = mu_hi;
                  mul_b  = mu_hi;
                  ph_in  = 3'd4;
               end
               default: begin
                  add_en   = 1'b1;
                  add_sh   = 6'(wsh) + 6'(2 * H);
                  smu_nx   = smu_ff + (SW'(cur.mu) << wsh);
                  sw_nx    = sw_ff + (5'd1 << wsh);
                  smu_in   = smu_nx;
                  sw_in    = sw_nx;
                  ph_in    = 3'd0;
                  acc_last = 1'b1;
               end
            endcase
            if (acc_last) begin
               ent_in = ent_ff + 4'd1;
               if (ent_ff == 4'd8) begin
                  if (sw_nx == '0) begin
                     res_in   = '0;
                     state_in = dmsf_pkg::S_OUT;
                  end else begin
                     nq_in    = {smu_nx, {(NQW-SW){1'b0}}};
                     dvs_in   = 16'(sw_nx);
                     rem_in   = '0;
                     cnt_in   = CNTW'(SW);
                     state_in = dmsf_pkg::S_DIVZ;
                  end
               end
            end
         end

         // mu_z = sum(w*mu) / sW
         dmsf_pkg::S_DIVZ: begin
            if (cnt_ff != '0) begin
               nq_in  = div_nq;
               rem_in = div_r[15:0];
               cnt_in = cnt_ff - CNTW'(1);
            end else begin
               muz_in   = nq_ff[MW-1:0];
               nq_in    = acc_ff;
               rem_in   = '0;
               cnt_in   = CNTW'(NQW);
               state_in = dmsf_pkg::S_DIVM;
            end
         end

         // m2 = sum(w*(s^2+mu^2)) / sW
         dmsf_pkg::S_DIVM: begin
            if (cnt_ff != '0) begin
               nq_in  = div_nq;
               rem_in = div_r[15:0];
               cnt_in = cnt_ff - CNTW'(1);
            end else begin
               acc_in   = '0;
               ph_in    = '0;
               state_in = dmsf_pkg::S_SQ;
            end
         end

         // mu_z squared from three partial products
         dmsf_pkg::S_SQ: begin
            unique case (ph_ff)
               3'd0: begin
                  mul_a = mu_lo;
                  mul_b = mu_lo;
                  ph_in = 3'd1;
               end
               3'd1: begin
                  add_en = 1'b1;
                  mul_a  = mu_lo;
                  mul_b  = mu_hi;
                  ph_in  = 3'd2;
               end
               3'd2: begin
                  add_en = 1'b1;
                  add_sh = 6'(H + 1);
                  mul_a  = mu_hi;
                  mul_b  = mu_hi;
                  ph_in  = 3'd3;
               end
               default: begin
                  add_en   = 1'b1;
                  add_sh   = 6'(2 * H);
                  state_in = dmsf_pkg::S_VAR;
               end
            endcase
         end

         // variance with clamp and saturation
         dmsf_pkg::S_VAR: begin
            if (var_full[NQW]) begin
               res_in   = '0;
               state_in = dmsf_pkg::S_OUT;
            end else if (|var_full[NQW-1:48]) begin
               res_in   = dmsf_pkg::SIGMA_SAT;
               state_in = dmsf_pkg::S_OUT;
            end else begin
               nq_in    = {{(NQW-48){1'b0}}, var_full[47:0]};
               sr_in    = '0;
               root_in  = '0;
               cnt_in   = CNTW'(24);
               state_in = dmsf_pkg::S_SQRT;
            end
         end

         // integer square root, one result bit a step
         dmsf_pkg::S_SQRT: begin
            if (cnt_ff != '0) begin
               sr_in   = sq_r[24:0];
               root_in = {root_ff[22:0], sq_ge};
               nq_in   = {nq_ff[NQW-3:0], 2'b00};
               cnt_in  = cnt_ff - CNTW'(1);
            end else begin
               res_in   = root_ff;
               state_in = dmsf_pkg::S_OUT;
            end
         end

         // load the output register once it is free
         dmsf_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sigma_in = res_ff;
               rsp_last_in  = (emit_ff == fs - EW'(1));
               pend_n       = pend_ff - EW'(1);
               pend_in      = pend_n;
               emit_in      = (emit_n >= fs) ? '0 : emit_n;
               if (!real_ff && pend_n == '0) begin
                  col_in  = '0;
                  emit_in = '0;
               end
               state_in = dmsf_pkg::S_IDLE;
            end
         end

         default: state_in = dmsf_pkg::S_IDLE;
      endcase

      // shared multiplier and accumulator
      prod_in = mul_a * mul_b;
      if (add_en) begin
         acc_in = acc_ff + ({{(NQW-48){1'b0}}, prod_ff} << add_sh);
      end
   end

   assign wr_addr = col_cur_ff[AW-1:0];

   // Line store of the row two back
   always_ff @(posedge clock) begin
      if (mem_we) begin
         top_mem[wr_addr] <= mid_rd_ff;
      end
      if (rd_en) begin
         top_rd_ff <= top_mem[rd_addr];
      end
   end

   // Line store of the previous row
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mid_mem[wr_addr] <= new_ent;
      end
      if (rd_en) begin
         mid_rd_ff <= mid_mem[rd_addr];
      end
   end

   // Real-pixel flag per column of the previous row
   always_ff @(posedge clock) begin
      if (real_we) begin
         real_mem[real_addr] <= real_wd;
      end
      if (rd_en) begin
         mreal_rd_ff <= real_mem[rd_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dmsf_pkg::S_CLEAR;
         clr_ff       <= '0;
         fw_ff        <= dmsf_pkg::FRAME_WIDTH_RST;
         fh_ff        <= dmsf_pkg::FRAME_HEIGHT_RST;
         mind_ff      <= dmsf_pkg::MIN_DEPTH_RST;
         sfloor_ff    <= dmsf_pkg::SIGMA_FLOOR_RST;
         col_ff       <= '0;
         emit_ff      <= '0;
         pend_ff      <= '0;
         mreal_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fw_ff        <= fw_in;
         fh_ff        <= fh_in;
         mind_ff      <= mind_in;
         sfloor_ff    <= sfloor_in;
         col_ff       <= col_in;
         emit_ff      <= emit_in;
         pend_ff      <= pend_in;
         mreal_ff     <= mreal_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff       <= win_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      col_cur_ff   <= col_cur_in;
      in_depth_ff  <= in_depth_in;
      in_sigma_ff  <= in_sigma_in;
      real_ff      <= real_in;
      nq_ff        <= nq_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      cnt_ff       <= cnt_in;
      ent_ff       <= ent_in;
      ph_ff        <= ph_in;
      prod_ff      <= prod_in;
      smu_ff       <= smu_in;
      sw_ff        <= sw_in;
      muz_ff       <= muz_in;
      sr_ff        <= sr_in;
      root_ff      <= root_in;
      res_ff       <= res_in;
      rsp_sigma_ff <= rsp_sigma_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule
